FILE: hw/rtl/sle_pkg.sv
package sle_pkg;

    localparam int SLE_MAX_ENTRIES = 16;
    localparam int KIND_W          = 2;
    localparam int POS_W           = 8;
    localparam int VAL_W           = 32;
    localparam int STAT_W          = 2;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 2'd0,
        K_DELETE = 2'd1,
        K_READ   = 2'd2,
        K_FIND   = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_TOP,
        PTR_POS,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_SHIFT,
        S_INS_PUT,
        S_RD_ISSUE,
        S_RD_GRAB,
        S_DEL_SHIFT,
        S_FIND,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    load;
        t_ptr_op ptr_op;
        logic    rd;
        logic    move;
        logic    up;
        logic    put;
        logic    cap_vout;
        logic    cap_found;
        logic    st_wr;
        t_status st_val;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  ins_bad;
        logic  pos_top;
        logic  full;
        logic  rng_bad;
        logic  ptr_eq_lo;
        logic  ptr_lt_cnt;
        logic  rd_pend;
        logic  mv_pend;
        logic  match;
    } t_stat;

endpackage

FILE: hw/rtl/sle_if.sv
interface sle_req_if;
    logic                            valid;
    logic                            ready;
    logic [sle_pkg::KIND_W-1:0]      kind;
    logic [sle_pkg::POS_W-1:0]       position;
    logic signed [sle_pkg::VAL_W-1:0] value_in;

    modport source (output valid, kind, position, value_in, input ready);
    modport sink   (input valid, kind, position, value_in, output ready);
endinterface

interface sle_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [sle_pkg::STAT_W-1:0]       status;
    logic signed [sle_pkg::VAL_W-1:0] value_out;
    logic [sle_pkg::POS_W-1:0]        found_position;
    logic [sle_pkg::POS_W-1:0]        list_length;

    modport source (output valid, status, value_out, found_position, list_length, input ready);
    modport sink   (input valid, status, value_out, found_position, list_length, output ready);
endinterface

FILE: hw/rtl/sle_datapath.sv
module sle_datapath #(
    parameter int MAX_ENTRIES = sle_pkg::SLE_MAX_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sle_pkg::t_cmd                   i_cmd,
    output sle_pkg::t_stat                  o_stat,
    input  logic [sle_pkg::KIND_W-1:0]      i_kind,
    input  logic [sle_pkg::POS_W-1:0]       i_position,
    input  logic signed [sle_pkg::VAL_W-1:0] i_value_in,
    output logic [sle_pkg::STAT_W-1:0]      o_status,
    output logic signed [sle_pkg::VAL_W-1:0] o_value_out,
    output logic [sle_pkg::POS_W-1:0]       o_found_position,
    output logic [sle_pkg::POS_W-1:0]       o_list_length
);
    import sle_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [VAL_W-1:0] mem [MAX_ENTRIES];

    t_kind            r_kind;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_ptr;
    logic [CW-1:0]    n_ptr;
    logic [VAL_W-1:0] r_rdata;
    logic [IW-1:0]    r_rd_addr;
    logic             r_rd_pend;
    logic             r_mv_pend;
    logic             r_mv_up;
    t_status          r_status;
    logic [VAL_W-1:0] r_vout;
    logic [POS_W-1:0] r_found;

    t_status          r_o_status;
    logic [VAL_W-1:0] r_o_vout;
    logic [POS_W-1:0] r_o_found;
    logic [POS_W-1:0] r_o_len;

    logic [POS_W:0]   w_pos9;
    logic [POS_W:0]   w_cnt9;
    logic [POS_W:0]   w_ptr9;
    logic [IW-1:0]    w_pos_idx;
    logic [IW-1:0]    w_mv_addr;

    assign w_pos9    = {1'b0, r_pos};
    assign w_cnt9    = (POS_W + 1)'(r_cnt);
    assign w_ptr9    = (POS_W + 1)'(r_ptr);
    assign w_pos_idx = IW'(r_pos - 8'd1);
    assign w_mv_addr = r_mv_up ? IW'(r_rd_addr + 1'b1) : IW'(r_rd_addr - 1'b1);

    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.ins_bad    = (r_pos == '0) || (w_pos9 > w_cnt9 + 1'b1);
        o_stat.pos_top    = (w_pos9 == w_cnt9 + 1'b1);
        o_stat.full       = (r_cnt == CW'(MAX_ENTRIES));
        o_stat.rng_bad    = (r_pos == '0) || (w_pos9 > w_cnt9);
        o_stat.ptr_eq_lo  = (w_ptr9 + 1'b1 == w_pos9);
        o_stat.ptr_lt_cnt = (r_ptr < r_cnt);
        o_stat.rd_pend    = r_rd_pend;
        o_stat.mv_pend    = r_mv_pend;
        o_stat.match      = r_rd_pend && (r_rdata == r_val);
    end

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_HOLD: n_ptr = r_ptr;
            PTR_TOP:  n_ptr = r_cnt - 1'b1;
            PTR_POS:  n_ptr = CW'(r_pos - 8'd1);
            PTR_ZERO: n_ptr = '0;
            PTR_INC:  n_ptr = r_ptr + 1'b1;
            PTR_DEC:  n_ptr = r_ptr - 1'b1;
            default:  n_ptr = r_ptr;
        endcase
    end

    // store: one registered read, one write (pending move first, then the new word)
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= mem[r_ptr[IW-1:0]];
        end
        if (r_mv_pend) begin
            mem[w_mv_addr] <= r_rdata;
        end else if (i_cmd.put) begin
            mem[w_pos_idx] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_rd_pend <= 1'b0;
            r_mv_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd;
            r_mv_pend <= i_cmd.rd && i_cmd.move;
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.rd) begin
            r_rd_addr <= r_ptr[IW-1:0];
            r_mv_up   <= i_cmd.up;
        end
        if (i_cmd.load) begin
            r_kind   <= t_kind'(i_kind);
            r_pos    <= i_position;
            r_val    <= i_value_in;
            r_status <= ST_OK;
            r_vout   <= '0;
            r_found  <= '0;
        end else begin
            if (i_cmd.st_wr) begin
                r_status <= i_cmd.st_val;
            end
            if (i_cmd.cap_vout) begin
                r_vout <= r_rdata;
            end
            if (i_cmd.cap_found) begin
                r_found <= POS_W'(r_rd_addr) + 8'd1;
            end
        end
        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_vout   <= r_vout;
            r_o_found  <= r_found;
            r_o_len    <= POS_W'(r_cnt);
        end
    end

    assign o_status         = r_o_status;
    assign o_value_out      = r_o_vout;
    assign o_found_position = r_o_found;
    assign o_list_length    = r_o_len;

endmodule

FILE: hw/rtl/sle_ctrl.sv
module sle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    input  sle_pkg::t_stat i_stat,
    output sle_pkg::t_cmd  o_cmd
);
    import sle_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                case (i_stat.kind)
                    K_INSERT: begin
                        if (i_stat.ins_bad || i_stat.full) n_state = S_DONE;
                        else if (i_stat.pos_top)           n_state = S_INS_PUT;
                        else                               n_state = S_INS_SHIFT;
                    end
                    K_DELETE, K_READ: begin
                        if (i_stat.rng_bad) n_state = S_DONE;
                        else                n_state = S_RD_ISSUE;
                    end
                    default: n_state = S_FIND;
                endcase
            end
            S_INS_SHIFT: begin
                if (i_stat.ptr_eq_lo) n_state = S_INS_PUT;
            end
            S_INS_PUT: begin
                if (!i_stat.mv_pend) n_state = S_DONE;
            end
            S_RD_ISSUE: n_state = S_RD_GRAB;
            S_RD_GRAB: begin
                if (i_stat.kind == K_DELETE) n_state = S_DEL_SHIFT;
                else                         n_state = S_DONE;
            end
            S_DEL_SHIFT: begin
                if (!i_stat.ptr_lt_cnt && !i_stat.mv_pend) n_state = S_DONE;
            end
            S_FIND: begin
                if (i_stat.match) n_state = S_DONE;
                else if (!i_stat.ptr_lt_cnt && !i_stat.rd_pend) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.ptr_op = PTR_HOLD;
        o_cmd.st_val = ST_OK;
        o_req_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_CHECK: begin
                case (i_stat.kind)
                    K_INSERT: begin
                        if (i_stat.ins_bad) begin
                            o_cmd.st_wr  = 1'b1;
                            o_cmd.st_val = ST_RANGE;
                        end else if (i_stat.full) begin
                            o_cmd.st_wr  = 1'b1;
                            o_cmd.st_val = ST_FULL;
                        end else if (!i_stat.pos_top) begin
                            o_cmd.ptr_op = PTR_TOP;
                        end
                    end
                    K_DELETE, K_READ: begin
                        if (i_stat.rng_bad) begin
                            o_cmd.st_wr  = 1'b1;
                            o_cmd.st_val = ST_RANGE;
                        end else begin
                            o_cmd.ptr_op = PTR_POS;
                        end
                    end
                    default: o_cmd.ptr_op = PTR_ZERO;
                endcase
            end
            S_INS_SHIFT: begin
                // walk down from the top, each word moved up one place
                o_cmd.rd     = 1'b1;
                o_cmd.move   = 1'b1;
                o_cmd.up     = 1'b1;
                o_cmd.ptr_op = i_stat.ptr_eq_lo ? PTR_HOLD : PTR_DEC;
            end
            S_INS_PUT: begin
                // hold until the last move has landed
                o_cmd.put     = !i_stat.mv_pend;
                o_cmd.cnt_inc = !i_stat.mv_pend;
            end
            S_RD_ISSUE: begin
                o_cmd.rd     = 1'b1;
                o_cmd.ptr_op = PTR_INC;
            end
            S_RD_GRAB: begin
                o_cmd.cap_vout = 1'b1;
            end
            S_DEL_SHIFT: begin
                if (i_stat.ptr_lt_cnt) begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.move   = 1'b1;
                    o_cmd.ptr_op = PTR_INC;
                end else if (!i_stat.mv_pend) begin
                    o_cmd.cnt_dec = 1'b1;
                end
            end
            S_FIND: begin
                if (i_stat.match) begin
                    o_cmd.cap_found = 1'b1;
                end else if (i_stat.ptr_lt_cnt) begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.ptr_op = PTR_INC;
                end
            end
            S_DONE: begin
                o_cmd.emit = w_slot_free;
            end
            default: o_cmd.ptr_op = PTR_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;

endmodule

FILE: hw/rtl/sequential_list_engine.sv
// Ordered list of signed 32-bit words held in a local store of MAX_ENTRIES
// entries, with a current length.
// Request channel i_req (valid/ready): kind 0 insert, 1 delete, 2 read,
// 3 find; position is 1-based, value_in is the word to insert or look for.
// Response channel o_rsp (valid/ready): one word per request with status
// (0 ok, 1 bad position, 2 full), value_out, found_position, list_length.
// One request is worked at a time. The store has a single read and a single
// write port, so entries are moved one at a time:
//   insert  moves entries from the top down to position up one place, then
//           writes the new word (no move when position = length+1);
//   delete  reads the entry at position, then moves each later one down; read
//           only reads the entry; find reads entries from the first until a
//           match or the end; rejected requests touch no entry.
// The response sits in an output register: a stalled receiver holds it, and
// the next request is accepted and worked meanwhile, finishing into that
// register once it empties. Reset empties the list and the output register;
// the store contents are not cleared.
module sequential_list_engine #(
    parameter int MAX_ENTRIES = sle_pkg::SLE_MAX_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sle_req_if.sink     i_req,
    sle_rsp_if.source   o_rsp
);
    import sle_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sle_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_kind           (i_req.kind),
        .i_position       (i_req.position),
        .i_value_in       (i_req.value_in),
        .o_status         (o_rsp.status),
        .o_value_out      (o_rsp.value_out),
        .o_found_position (o_rsp.found_position),
        .o_list_length    (o_rsp.list_length)
    );

endmodule
